### src/wsi_pkg.sv
// ----------------------------------------------------------------------------
// wsi_pkg: shared definitions for the windowed cubic sample interpolator
// Sample store geometry, request codes, entry layout and small helpers.
// ----------------------------------------------------------------------------
package wsi_pkg;

  localparam int SAMPLE_DEPTH = 32;
  localparam int IDX_W  = $clog2(SAMPLE_DEPTH);
  localparam int CNT_W  = $clog2(SAMPLE_DEPTH + 1);
  localparam int TIME_W = 32;
  localparam int VAL_W  = 16;
  localparam int MU_W   = 17;
  localparam int COEF_W = 20;
  localparam int ACC_W  = 40;
  localparam int SUM_W  = ACC_W - 16 + 1;

  localparam logic [MU_W-1:0] MU_ONE = MU_W'(65536);
  localparam logic [ACC_W-1:0] ACC_HALF = ACC_W'(32768);

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0]       t;
    logic signed [VAL_W-1:0] x;
    logic signed [VAL_W-1:0] y;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] num;
    logic [TIME_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [MU_W-1:0] quo;
  } div_rsp_t;

  // Ring slot of the k-th sample counted from the oldest one.
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] k);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(k);
    if (sum >= (CNT_W+1)'(SAMPLE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(SAMPLE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // Average rounded toward minus infinity.
  function automatic logic signed [VAL_W-1:0] avg2(input logic signed [VAL_W-1:0] a,
                                                   input logic signed [VAL_W-1:0] b);
    logic signed [VAL_W:0] s;
    s = (VAL_W+1)'(a) + (VAL_W+1)'(b);
    return s[VAL_W:1];
  endfunction

  function automatic logic signed [VAL_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > SUM_W'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -(SUM_W'(32768))) begin
      r = 16'sh8000;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

### src/wsi_div.sv
// ----------------------------------------------------------------------------
// wsi_div: blend weight divider
// Restoring divider, one quotient bit per cycle, giving (num << 16) / den.
// ----------------------------------------------------------------------------
module wsi_div import wsi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [TIME_W:0]   rem_r, rem_nxt;
  logic [TIME_W-1:0] den_r, den_nxt;
  logic [MU_W-1:0]   quo_r, quo_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              ge;
  logic [TIME_W:0]   diff;

  always_comb begin
    ge   = rem_r >= {1'b0, den_r};
    diff = ge ? rem_r - {1'b0, den_r} : rem_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = {1'b0, req.num};
      den_nxt  = req.den;
      quo_nxt  = '0;
      cnt_nxt  = 5'(MU_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[MU_W-2:0], ge};
      rem_nxt = {diff[TIME_W-1:0], 1'b0};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

### src/windowed_cubic_sample_interpolator.sv
// ----------------------------------------------------------------------------
// windowed_cubic_sample_interpolator: windowed store of timed 2-D samples
// Keeps a ring of timestamped samples and answers time queries by four-point
// cubic interpolation between the samples that bracket the query time.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake               Payload
// in_       slave      in_tvalid / in_tready   tdata: time, x, y; tuser: request
// out_      master     out_tvalid / out_tready tdata: x, y; tuser: has_samples
// cfg_      slave      cfg_valid / cfg_ready   cfg_data: window duration
//
// One item at a time. An add reads back the newest sample, drops samples by
// age and then writes, or writes at once on an empty store. An interpolating
// query scans the single-port sample memory up to the bracket, reading one
// neighbour past it unless the bracket ends at the newest sample, then waits
// for the bit-serial divider, which needs 17 steps and then flags completion.
// A query answered without interpolation skips the divider. A clear gives no
// result. Reset is synchronous, active low, and empties the store without
// touching the sample memory. A finished result waits in the output register
// while the next transfer is taken; only a second result stalls the block
// until the first one is taken.
module windowed_cubic_sample_interpolator import wsi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // sample_time[31:0], value_x[47:32], value_y[63:48]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // result_x[15:0], result_y[31:16]
  output logic        out_tuser,  // has_samples[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_ADD_NEW = 4'd1;
  localparam logic [3:0] ST_ADD_PRN = 4'd2;
  localparam logic [3:0] ST_ADD_WR  = 4'd3;
  localparam logic [3:0] ST_Q_FIRST = 4'd4;
  localparam logic [3:0] ST_Q_SCAN  = 4'd5;
  localparam logic [3:0] ST_Q_P3    = 4'd6;
  localparam logic [3:0] ST_Q_DIVGO = 4'd7;
  localparam logic [3:0] ST_Q_DIVW  = 4'd8;
  localparam logic [3:0] ST_Q_MU2   = 4'd9;
  localparam logic [3:0] ST_Q_MU3   = 4'd10;
  localparam logic [3:0] ST_Q_MAC   = 4'd11;
  localparam logic [3:0] ST_Q_FIN   = 4'd12;
  localparam logic [3:0] ST_EMIT    = 4'd13;

  // Sample memory: one write port, one registered read port.
  entry_t            mem [SAMPLE_DEPTH];
  entry_t            rdata_r;
  logic [IDX_W-1:0]  raddr, waddr;
  logic              we;
  entry_t            wdata;

  logic [3:0]        state_r, state_nxt;
  logic [31:0]       window_r;
  logic [IDX_W-1:0]  oldest_r, oldest_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  k2_r, k2_nxt;
  logic [TIME_W-1:0] t_r;
  logic signed [VAL_W-1:0] vx_r, vy_r;
  entry_t            new_r, e0_r, e1_r, e2_r, e3_r;
  logic [IDX_W-1:0]  new_idx_r;
  logic [TIME_W-1:0] thr_r;
  logic [MU_W-1:0]   mu_r, mu2_r, mu3_r;
  logic signed [COEF_W-1:0] ax0_r, ax1_r, ax2_r, ay0_r, ay1_r, ay2_r;
  logic signed [ACC_W-1:0]  accx_r, accy_r;
  logic [2:0]        mac_r;
  logic signed [VAL_W-1:0] res_x_r, res_y_r, out_x_r, out_y_r;
  logic              res_has_r, out_has_r, out_valid_r;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic [CNT_W:0]    k2_inc;
  logic [2*MU_W-1:0] mu_sq, mu_cu;
  logic signed [COEF_W-1:0] c_sel;
  logic signed [MU_W:0]     m_sel;
  logic signed [COEF_W+MU_W:0] prod;
  logic signed [COEF_W-1:0] p0x, p1x, p2x, p3x, p0y, p1y, p2y, p3y;
  logic signed [COEF_W-1:0] cx0, cy0;
  logic signed [SUM_W-1:0]  fin_x, fin_y;

  wsi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_y_r, out_x_r};
  assign out_tuser  = out_has_r;

  assign k2_inc = (CNT_W+1)'(k2_r) + (CNT_W+1)'(1);

  // Cubic coefficients from the four neighbours.
  assign p0x = COEF_W'(e0_r.x);
  assign p1x = COEF_W'(e1_r.x);
  assign p2x = COEF_W'(e2_r.x);
  assign p3x = COEF_W'(e3_r.x);
  assign p0y = COEF_W'(e0_r.y);
  assign p1y = COEF_W'(e1_r.y);
  assign p2y = COEF_W'(e2_r.y);
  assign p3y = COEF_W'(e3_r.y);
  assign cx0 = p3x - p2x - p0x + p1x;
  assign cy0 = p3y - p2y - p0y + p1y;

  assign mu_sq = mu_r * mu_r;
  assign mu_cu = mu2_r * mu_r;

  // One multiplier shared over the six terms of both components.
  always_comb begin
    case (mac_r)
      3'd0:    begin c_sel = ax0_r; m_sel = signed'({1'b0, mu3_r}); end
      3'd1:    begin c_sel = ax1_r; m_sel = signed'({1'b0, mu2_r}); end
      3'd2:    begin c_sel = ax2_r; m_sel = signed'({1'b0, mu_r});  end
      3'd3:    begin c_sel = ay0_r; m_sel = signed'({1'b0, mu3_r}); end
      3'd4:    begin c_sel = ay1_r; m_sel = signed'({1'b0, mu2_r}); end
      default: begin c_sel = ay2_r; m_sel = signed'({1'b0, mu_r});  end
    endcase
    prod = c_sel * m_sel;
  end

  // Floor shift of the accumulator, then the p1 offset.
  assign fin_x = SUM_W'(e1_r.x) + SUM_W'(accx_r >>> 16);
  assign fin_y = SUM_W'(e1_r.y) + SUM_W'(accy_r >>> 16);

  always_comb begin
    state_nxt  = state_r;
    oldest_nxt = oldest_r;
    count_nxt  = count_r;
    k2_nxt     = k2_r;
    raddr      = slot_of(oldest_r, '0);
    waddr      = new_idx_r;
    we         = 1'b0;
    wdata      = new_r;
    div_req.start = 1'b0;
    div_req.num   = t_r - e1_r.t;
    div_req.den   = e2_r.t - e1_r.t;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          unique case (in_tuser)
            REQ_ADD: begin
              if (count_r == '0) begin
                state_nxt = ST_ADD_WR;
              end else begin
                raddr     = slot_of(oldest_r, count_r - CNT_W'(1));
                state_nxt = ST_ADD_NEW;
              end
            end
            REQ_QUERY: begin
              state_nxt = (count_r == '0) ? ST_EMIT : ST_Q_FIRST;
            end
            REQ_CLEAR: begin
              count_nxt  = '0;
              oldest_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_ADD_NEW: begin
        state_nxt = ST_ADD_PRN;
      end
      ST_ADD_PRN: begin
        // The newest sample is never older than the threshold, so this ends.
        if (rdata_r.t < thr_r && count_r != '0) begin
          oldest_nxt = slot_of(oldest_r, CNT_W'(1));
          count_nxt  = count_r - CNT_W'(1);
          raddr      = slot_of(oldest_r, CNT_W'(1));
        end else begin
          state_nxt = ST_ADD_WR;
        end
      end
      ST_ADD_WR: begin
        we = 1'b1;
        if (count_r != '0 && new_r.t == t_r) begin
          waddr   = new_idx_r;
          wdata.t = new_r.t;
          wdata.x = avg2(new_r.x, vx_r);
          wdata.y = avg2(new_r.y, vy_r);
        end else begin
          waddr   = slot_of(oldest_r, count_r);
          wdata.t = t_r;
          wdata.x = vx_r;
          wdata.y = vy_r;
          if (count_r >= CNT_W'(SAMPLE_DEPTH)) begin
            oldest_nxt = slot_of(oldest_r, CNT_W'(1));
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        state_nxt = ST_IDLE;
      end
      ST_Q_FIRST: begin
        k2_nxt = CNT_W'(1);
        if (t_r < rdata_r.t || count_r == CNT_W'(1)) begin
          state_nxt = ST_EMIT;
        end else begin
          raddr     = slot_of(oldest_r, CNT_W'(1));
          state_nxt = ST_Q_SCAN;
        end
      end
      ST_Q_SCAN: begin
        if (t_r > rdata_r.t) begin
          if (k2_inc >= (CNT_W+1)'(count_r)) begin
            state_nxt = ST_EMIT;
          end else begin
            k2_nxt = k2_inc[CNT_W-1:0];
            raddr  = slot_of(oldest_r, k2_inc[CNT_W-1:0]);
          end
        end else if (e1_r.t == rdata_r.t) begin
          state_nxt = ST_EMIT;
        end else if (k2_inc < (CNT_W+1)'(count_r)) begin
          raddr     = slot_of(oldest_r, k2_inc[CNT_W-1:0]);
          state_nxt = ST_Q_P3;
        end else begin
          state_nxt = ST_Q_DIVGO;
        end
      end
      ST_Q_P3: begin
        state_nxt = ST_Q_DIVGO;
      end
      ST_Q_DIVGO: begin
        div_req.start = 1'b1;
        state_nxt     = ST_Q_DIVW;
      end
      ST_Q_DIVW: begin
        if (div_rsp.done) begin
          state_nxt = ST_Q_MU2;
        end
      end
      ST_Q_MU2: state_nxt = ST_Q_MU3;
      ST_Q_MU3: state_nxt = ST_Q_MAC;
      ST_Q_MAC: begin
        if (mac_r == 3'd5) begin
          state_nxt = ST_Q_FIN;
        end
      end
      ST_Q_FIN: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      oldest_r    <= '0;
      count_r     <= '0;
      window_r    <= 32'd65536;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      oldest_r <= oldest_nxt;
      count_r  <= count_nxt;
      if (cfg_valid) begin
        window_r <= cfg_data;
      end
      if (state_r == ST_EMIT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    k2_r <= k2_nxt;

    if (state_r == ST_IDLE && in_tvalid) begin
      t_r       <= in_tdata[31:0];
      vx_r      <= signed'(in_tdata[47:32]);
      vy_r      <= signed'(in_tdata[63:48]);
      res_x_r   <= '0;
      res_y_r   <= '0;
      res_has_r <= 1'b0;
    end

    if (state_r == ST_ADD_NEW) begin
      new_r     <= rdata_r;
      new_idx_r <= slot_of(oldest_r, count_r - CNT_W'(1));
      thr_r     <= (rdata_r.t >= window_r) ? rdata_r.t - window_r : '0;
    end

    if (state_r == ST_Q_FIRST) begin
      e0_r      <= rdata_r;
      e1_r      <= rdata_r;
      res_x_r   <= rdata_r.x;
      res_y_r   <= rdata_r.y;
      res_has_r <= 1'b1;
    end

    if (state_r == ST_Q_SCAN) begin
      if (t_r > rdata_r.t) begin
        // Past this sample: slide the neighbour window forward.
        e0_r    <= e1_r;
        e1_r    <= rdata_r;
        res_x_r <= rdata_r.x;
        res_y_r <= rdata_r.y;
      end else begin
        e2_r    <= rdata_r;
        e3_r    <= rdata_r;
        res_x_r <= avg2(e1_r.x, rdata_r.x);
        res_y_r <= avg2(e1_r.y, rdata_r.y);
      end
    end

    if (state_r == ST_Q_P3) begin
      e3_r <= rdata_r;
    end

    if (state_r == ST_Q_DIVW) begin
      mu_r  <= (div_rsp.quo > MU_ONE) ? MU_ONE : div_rsp.quo;
      ax0_r <= cx0;
      ax1_r <= p0x - p1x - cx0;
      ax2_r <= p2x - p0x;
      ay0_r <= cy0;
      ay1_r <= p0y - p1y - cy0;
      ay2_r <= p2y - p0y;
    end

    if (state_r == ST_Q_MU2) begin
      mu2_r <= mu_sq[MU_W+15:16];
    end

    if (state_r == ST_Q_MU3) begin
      mu3_r  <= mu_cu[MU_W+15:16];
      mac_r  <= '0;
      accx_r <= signed'(ACC_HALF);
      accy_r <= signed'(ACC_HALF);
    end

    if (state_r == ST_Q_MAC) begin
      mac_r <= mac_r + 3'd1;
      if (mac_r < 3'd3) begin
        accx_r <= accx_r + ACC_W'(prod);
      end else begin
        accy_r <= accy_r + ACC_W'(prod);
      end
    end

    if (state_r == ST_Q_FIN) begin
      res_x_r <= sat16(fin_x);
      res_y_r <= sat16(fin_y);
    end

    if (state_r == ST_EMIT && (!out_valid_r || out_tready)) begin
      out_x_r   <= res_x_r;
      out_y_r   <= res_y_r;
      out_has_r <= res_has_r;
    end
  end

endmodule

### src/wsi_chk.sv
// ----------------------------------------------------------------------------
// wsi_chk: port-level checks for the windowed cubic sample interpolator
// Watches the top-level ports and is attached by a bind statement.
// ----------------------------------------------------------------------------
module wsi_chk import wsi_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result payload changed while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 32'd0)
    else $error("empty-store result is not zero");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == REQ_QUERY |=> !in_tready)
    else $error("query transfer did not occupy the block");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared while the block was idle");

endmodule

bind windowed_cubic_sample_interpolator wsi_chk u_wsi_chk (.*);

### sim/windowed_cubic_sample_interpolator_tb.sv
// ----------------------------------------------------------------------------
// windowed_cubic_sample_interpolator_tb: self-checking bench for the interpolator
// Drives adds, queries and clears over the stream port under random idling.
// A scoreboard keeps its own copy of the sample ring and predicts each query
// result, which is then compared field by field with what the block returns.
// ----------------------------------------------------------------------------
module windowed_cubic_sample_interpolator_tb;
  import wsi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING = SAMPLE_DEPTH;
  localparam int STALL_LIMIT = 20000;
  // Request code the block ignores.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // One predicted or observed query answer.
  typedef struct packed {
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic               has;
  } answer_t;

  // Scoreboard: shadow sample ring, window register and pending answers.
  class interp_scoreboard;
    logic [31:0]        window;
    logic [31:0]        times [RING];
    logic signed [15:0] xs [RING];
    logic signed [15:0] ys [RING];
    int                 oldest;
    int                 count;
    answer_t            pending [$];
    int                 errors;

    function new();
      window = 32'd65536;
      oldest = 0;
      count  = 0;
      errors = 0;
    endfunction

    function int ring_slot(int k);
      return (oldest + k) % RING;
    endfunction

    // Average rounded toward minus infinity.
    function logic signed [15:0] half_sum(logic signed [15:0] a, logic signed [15:0] b);
      logic signed [16:0] s;
      s = 17'(a) + 17'(b);
      return s[16:1];
    endfunction

    function logic signed [15:0] blend(longint p0, longint p1, longint p2, longint p3,
                                       longint mu, longint mu2, longint mu3);
      longint a0, a1, a2, acc, v;
      a0  = p3 - p2 - p0 + p1;
      a1  = p0 - p1 - a0;
      a2  = p2 - p0;
      acc = a0 * mu3 + a1 * mu2 + a2 * mu + 32768;
      v   = p1 + (acc >>> 16);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    function void note_request(logic [1:0] kind, logic [31:0] t,
                               logic signed [15:0] vx, logic signed [15:0] vy);
      answer_t a;
      logic [31:0] newest, thr, t1, t2;
      int k1, k2, s0, s1, s2, s3;
      longint mu, mu2, mu3;
      if (kind == REQ_CLEAR) begin
        count  = 0;
        oldest = 0;
      end else if (kind == REQ_ADD) begin
        if (count > 0) begin
          newest = times[ring_slot(count - 1)];
          thr = (newest >= window) ? newest - window : 32'd0;
          while (count > 0 && times[ring_slot(0)] < thr) begin
            oldest = ring_slot(1);
            count--;
          end
        end
        if (count > 0 && times[ring_slot(count - 1)] == t) begin
          s1 = ring_slot(count - 1);
          xs[s1] = half_sum(xs[s1], vx);
          ys[s1] = half_sum(ys[s1], vy);
        end else begin
          if (count >= RING) begin
            oldest = ring_slot(1);
            count  = RING - 1;
          end
          s1 = ring_slot(count);
          times[s1] = t;
          xs[s1] = vx;
          ys[s1] = vy;
          count++;
        end
      end else if (kind == REQ_QUERY) begin
        a = '0;
        if (count > 0) begin
          a.has = 1'b1;
          k2 = 1;
          while (k2 < count && t > times[ring_slot(k2)]) k2++;
          if (t < times[ring_slot(0)]) begin
            a.rx = xs[ring_slot(0)];
            a.ry = ys[ring_slot(0)];
          end else if (k2 >= count) begin
            a.rx = xs[ring_slot(count - 1)];
            a.ry = ys[ring_slot(count - 1)];
          end else begin
            k1 = k2 - 1;
            s0 = ring_slot(k1 > 0 ? k1 - 1 : k1);
            s1 = ring_slot(k1);
            s2 = ring_slot(k2);
            s3 = ring_slot(k2 + 1 < count ? k2 + 1 : k2);
            t1 = times[s1];
            t2 = times[s2];
            if (t1 == t2) begin
              a.rx = half_sum(xs[s1], xs[s2]);
              a.ry = half_sum(ys[s1], ys[s2]);
            end else begin
              mu = ({32'd0, t - t1} << 16) / {32'd0, t2 - t1};
              if (mu > 65536) mu = 65536;
              mu2 = (mu * mu) >> 16;
              mu3 = (mu2 * mu) >> 16;
              a.rx = blend(xs[s0], xs[s1], xs[s2], xs[s3], mu, mu2, mu3);
              a.ry = blend(ys[s0], ys[s1], ys[s2], ys[s3], mu, mu2, mu3);
            end
          end
        end
        pending.push_back(a);
      end
    endfunction

    // Prints a line for each of the first 50 mismatches and keeps the count.
    task report_mismatch(string what, longint want, longint got);
      errors++;
      if (errors <= 50) $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
    endtask

    task check_answer(answer_t got);
      answer_t want;
      if (pending.size() == 0) begin
        report_mismatch("result with no query waiting", 0, got);
        return;
      end
      want = pending.pop_front();
      if (got.rx !== want.rx) report_mismatch("result_x", want.rx, got.rx);
      if (got.ry !== want.ry) report_mismatch("result_y", want.ry, got.ry);
      if (got.has !== want.has) report_mismatch("has_samples", want.has, got.has);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  windowed_cubic_sample_interpolator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  interp_scoreboard board;

  // Idle rates in percent for each side; the receiver stall gate is separate.
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_receiver;
  int  quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: random ready, forced low during the long back-pressure stretch.
  always @(posedge clk) begin
    if (!rst_n || hold_receiver) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result monitor: a transfer happens where valid and ready are both high.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_answer({out_tdata[15:0], out_tdata[31:16], out_tuser});
    end
  end

  // Watchdog: counts cycles with no transfer on any channel while the receiver is not held.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_valid && cfg_ready) || hold_receiver) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("windowed_cubic_sample_interpolator_tb: errors");
        $finish;
      end
    end
  end

  // Offers one request and waits for its transfer. Random idle cycles go
  // first; valid stays high after the transfer until the next idle cycle
  // or the next drain.
  task automatic send_request(logic [1:0] kind, logic [31:0] t,
                              logic [15:0] vx, logic [15:0] vy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {vy, vx, t};
    do @(posedge clk); while (!in_tready);
    board.note_request(kind, t, vx, vy);
  endtask

  // Waits for all outstanding answers, then idles the input so a last add can finish.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_window(logic [31:0] w);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.window = w;
  endtask

  // Random traffic on a clock whose step stays in a chosen range. Mostly
  // rising adds with queries around the stored span; a few clears and
  // backward or unused requests mixed in.
  task automatic random_phase(int n, logic [31:0] step_max);
    logic [31:0] now;
    logic [31:0] q;
    int pick;
    now = $urandom;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        if ($urandom_range(9) != 0) now = now + $urandom_range(step_max);
        send_request(REQ_ADD, ($urandom_range(49) == 0) ? $urandom : now,
                     16'($urandom), 16'($urandom));
      end else if (pick < 95) begin
        q = now - $urandom_range(step_max) * $urandom_range(40);
        if ($urandom_range(9) == 0) q = $urandom;
        send_request(REQ_QUERY, q, 16'($urandom), 16'($urandom));
      end else if (pick < 98) begin
        send_request(REQ_CLEAR, $urandom, 16'($urandom), 16'($urandom));
      end else begin
        send_request(REQ_UNUSED, $urandom, 16'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = REQ_ADD;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    send_idle_pct = 12;
    recv_idle_pct = 53;
    hold_receiver = 1'b0;
    quiet_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty-store query, extremes, equal-time average,
    // single sample, before-first and after-last, unused code and clear.
    send_request(REQ_QUERY, 32'h0, 16'h0, 16'h0);
    send_request(REQ_ADD, 32'h0001_0000, 16'h7fff, 16'h8000);
    send_request(REQ_QUERY, 32'h0002_0000, 16'h0, 16'h0);
    send_request(REQ_ADD, 32'h0001_0000, 16'h7fff, 16'h7fff);
    send_request(REQ_ADD, 32'h0001_4000, 16'h8000, 16'h7fff);
    send_request(REQ_ADD, 32'h0001_8000, 16'h7fff, 16'h8000);
    send_request(REQ_ADD, 32'h0001_8000, 16'h0001, 16'hffff);
    send_request(REQ_ADD, 32'h0001_c000, 16'h8000, 16'h7fff);
    send_request(REQ_QUERY, 32'h0000_0000, 16'hffff, 16'hffff);
    send_request(REQ_QUERY, 32'h0001_2000, 16'h0, 16'h0);
    send_request(REQ_QUERY, 32'h0001_5555, 16'h0, 16'h0);
    send_request(REQ_QUERY, 32'h0001_c000, 16'h0, 16'h0);
    send_request(REQ_QUERY, 32'hffff_ffff, 16'h0, 16'h0);
    send_request(REQ_UNUSED, 32'hffff_ffff, 16'hffff, 16'hffff);
    send_request(REQ_CLEAR, 32'h0, 16'h0, 16'h0);
    send_request(REQ_QUERY, 32'h1234_5678, 16'h0, 16'h0);
    // Two samples at the same time after a decreasing add, queried before the first and at the newest.
    send_request(REQ_ADD, 32'h0005_0000, 16'h0100, 16'hff00);
    send_request(REQ_ADD, 32'h0004_0000, 16'h0300, 16'h0101);
    send_request(REQ_ADD, 32'h0005_0000, 16'h0200, 16'h0002);
    send_request(REQ_QUERY, 32'h0004_8000, 16'h0, 16'h0);
    send_request(REQ_QUERY, 32'h0005_0000, 16'h0, 16'h0);

    // Window at its minimum: age drop on nearly every add.
    write_window(32'd0);
    random_phase(150, 32'h0000_4000);
    // Window at its maximum with small steps: the ring fills and wraps.
    write_window(32'hffff_ffff);
    random_phase(300, 32'h0000_0100);

    // Back-pressure: receiver held off while queries keep coming.
    fork
      begin
        hold_receiver = 1'b1;
        repeat (3000) @(posedge clk);
        hold_receiver = 1'b0;
      end
      random_phase(40, 32'h0000_1000);
    join

    write_window(32'h0004_0000);
    random_phase(500, 32'h0000_8000);

    send_idle_pct = 53;
    recv_idle_pct = 12;
    write_window(32'h0000_1000);
    random_phase(500, 32'h0000_0400);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_window(32'h0010_0000);
    random_phase(500, 32'h0001_0000);

    drain();
    if (board.pending.size() == 0 && board.errors == 0) begin
      $display("windowed_cubic_sample_interpolator_tb: clean");
    end else begin
      $display("windowed_cubic_sample_interpolator_tb: errors");
    end
    $finish;
  end

endmodule

### files.f
src/wsi_pkg.sv
src/wsi_div.sv
src/windowed_cubic_sample_interpolator.sv
src/wsi_chk.sv
sim/windowed_cubic_sample_interpolator_tb.sv
